// File: hw/rtl/pil_pkg.sv
// Package for the positional insert list: operation and status codes,
// default depth and the control bundle that the top level broadcasts to the cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pil_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W = 32;
	localparam int MODE_W = 2;
	localparam int POS_W = 7;
	localparam int CNT_OUT_W = 7;
	localparam int STAT_W = 2;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic wr_en;
		logic srch_en;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/pil_if.sv
// Valid/ready channel interfaces for the positional insert list: input item
// channel and result channel. Depends on pil_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pil_in_if;
	logic valid;
	logic ready;
	logic [pil_pkg::MODE_W-1:0] mode;
	logic signed [pil_pkg::VAL_W-1:0] value;
	logic [pil_pkg::POS_W-1:0] position;

	modport source (output valid, mode, value, position, input ready);
	modport sink (input valid, mode, value, position, output ready);
endinterface

interface pil_out_if;
	logic valid;
	logic ready;
	logic found;
	logic [pil_pkg::CNT_OUT_W-1:0] count;
	logic [pil_pkg::STAT_W-1:0] status;

	modport source (output valid, found, count, status, input ready);
	modport sink (input valid, found, count, status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pil_cell.sv
// One storage cell of the positional insert list: holds one value, takes its
// left neighbour's value on a shifting insert and compares on a search. Depends on pil_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pil_cell #(
	parameter int IDX = 0,
	parameter int PW = 7
) (
	input wire logic clk,
	input wire pil_pkg::cell_ctl_t ctl,
	input wire logic [PW-1:0] wr_pos,
	input wire logic [PW-1:0] cnt,
	input wire logic signed [pil_pkg::VAL_W-1:0] left_val,
	output logic signed [pil_pkg::VAL_W-1:0] val,
	output logic hit
);

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic signed [pil_pkg::VAL_W-1:0] val_q;
	logic hit_q;
	logic occupied;

	assign occupied = MY_IDX < cnt;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			if (MY_IDX == wr_pos) begin
				val_q <= ctl.value;
			end else if (MY_IDX > wr_pos && MY_IDX <= cnt) begin
				val_q <= left_val;
			end
		end
		if (ctl.srch_en) begin
			hit_q <= occupied && (val_q == ctl.value);
		end
	end

	assign val = val_q;
	assign hit = hit_q;

endmodule
`default_nettype wire

// File: hw/rtl/positional_insert_list_top.sv
// Positional insert list: a row of DEPTH cells holding an ordered sequence.
// Insert, append and no-op transactions give their result in the cycle after acceptance;
// a search registers a match in every cell, then reduces them into the result register.
// One transaction is accepted per cycle while the result slot is free; a search blocks
// intake until its result is registered. Reset clears the fill count and the control
// state; cell contents are not reset. Depends on pil_pkg, pil_if and pil_cell.
`timescale 1ns / 1ps
`default_nettype none
module positional_insert_list_top #(
	parameter int DEPTH = pil_pkg::DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pil_in_if.sink items,
	pil_out_if.source results
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > pil_pkg::POS_W) ? CW : pil_pkg::POS_W;
	localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SEARCH = 1'b1;

	logic state_q;
	logic [CW-1:0] cnt_q;
	logic res_vld_q;
	logic res_found_q;
	logic [pil_pkg::CNT_OUT_W-1:0] res_count_q;
	logic [pil_pkg::STAT_W-1:0] res_status_q;

	logic slot_free;
	logic in_fire;
	logic is_ins;
	logic is_app;
	logic is_srch;
	logic range_err;
	logic full_err;
	logic do_wr;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic [PW-1:0] wr_pos;
	logic [pil_pkg::STAT_W-1:0] status_n;
	pil_pkg::cell_ctl_t ctl;

	logic signed [pil_pkg::VAL_W-1:0] vals [DEPTH];
	logic [DEPTH-1:0] hits;

	assign slot_free = !res_vld_q || results.ready;
	assign items.ready = (state_q == S_IDLE) && slot_free;
	assign in_fire = items.valid && items.ready;

	always_comb begin
		is_ins = items.mode == pil_pkg::MODE_INSERT;
		is_app = items.mode == pil_pkg::MODE_APPEND;
		is_srch = items.mode == pil_pkg::MODE_SEARCH;
		pos_w = PW'(items.position);
		cnt_w = PW'(cnt_q);
		range_err = is_ins && (pos_w > cnt_w);
		full_err = ((is_ins && !range_err) || is_app) && (cnt_w >= DEPTH_W);
		do_wr = in_fire && (is_ins || is_app) && !range_err && !full_err;
		wr_pos = is_app ? cnt_w : pos_w;
		if (range_err) begin
			status_n = pil_pkg::ST_RANGE;
		end else if (full_err) begin
			status_n = pil_pkg::ST_FULL;
		end else begin
			status_n = pil_pkg::ST_OK;
		end
		ctl.wr_en = do_wr;
		ctl.srch_en = in_fire && is_srch;
		ctl.value = items.value;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			pil_cell #(.IDX(i), .PW(PW)) u_cell (
				.clk(clk),
				.ctl(ctl),
				.wr_pos(wr_pos),
				.cnt(cnt_w),
				.left_val(items.value),
				.val(vals[i]),
				.hit(hits[i])
			);
		end else begin : g_rest
			pil_cell #(.IDX(i), .PW(PW)) u_cell (
				.clk(clk),
				.ctl(ctl),
				.wr_pos(wr_pos),
				.cnt(cnt_w),
				.left_val(vals[i-1]),
				.val(vals[i]),
				.hit(hits[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && is_srch) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (do_wr) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (in_fire && !is_srch) begin
				res_vld_q <= 1'b1;
			end else if (state_q == S_SEARCH && slot_free) begin
				res_vld_q <= 1'b1;
			end else if (results.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !is_srch) begin
			res_found_q <= 1'b0;
			res_status_q <= status_n;
			if (do_wr) begin
				res_count_q <= pil_pkg::CNT_OUT_W'(cnt_q + CW'(1));
			end else begin
				res_count_q <= pil_pkg::CNT_OUT_W'(cnt_q);
			end
		end else if (state_q == S_SEARCH && slot_free) begin
			res_found_q <= |hits;
			res_status_q <= pil_pkg::ST_OK;
			res_count_q <= pil_pkg::CNT_OUT_W'(cnt_q);
		end
	end

	assign results.valid = res_vld_q;
	assign results.found = res_found_q;
	assign results.count = res_count_q;
	assign results.status = res_status_q;

endmodule
`default_nettype wire

// File: tb/sv/positional_insert_list_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_insert_list_top: a scoreboard class tracks the
// held sequence and checks every result transaction against its own prediction.
// Depends on pil_pkg, pil_if and the RTL of the block.
module positional_insert_list_top_tb;
	import pil_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
	localparam int RANDOM_ITEMS = 1230;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic found;
		logic [CNT_OUT_W-1:0] count;
		logic [STAT_W-1:0] status;
	} outcome_t;

	class insert_list_tracker;
		logic signed [VAL_W-1:0] cells [DEPTH];
		int fill;
		outcome_t pending_outcomes [$];
		int errors;
		int n_added, n_search, n_hit, n_range, n_full, n_nop;

		function new();
			fill = 0;
			errors = 0;
			n_added = 0;
			n_search = 0;
			n_hit = 0;
			n_range = 0;
			n_full = 0;
			n_nop = 0;
		endfunction

		function void place(int at, logic signed [VAL_W-1:0] v);
			int i;
			for (i = fill; i > at; i--)
				cells[i] = cells[i - 1];
			cells[at] = v;
			fill++;
			n_added++;
		endfunction

		function void accept_item(logic [MODE_W-1:0] mode, logic signed [VAL_W-1:0] v,
				logic [POS_W-1:0] position);
			outcome_t exp;
			int i;
			exp.found = 1'b0;
			exp.status = ST_OK;
			case (mode)
				MODE_INSERT: begin
					if (int'(position) > fill)
						exp.status = ST_RANGE;
					else if (fill >= DEPTH)
						exp.status = ST_FULL;
					else
						place(int'(position), v);
				end
				MODE_APPEND: begin
					if (fill >= DEPTH)
						exp.status = ST_FULL;
					else
						place(fill, v);
				end
				MODE_SEARCH: begin
					n_search++;
					for (i = 0; i < fill; i++)
						if (cells[i] == v)
							exp.found = 1'b1;
					if (exp.found)
						n_hit++;
				end
				default: begin
					n_nop++;
				end
			endcase
			if (exp.status == ST_RANGE)
				n_range++;
			if (exp.status == ST_FULL)
				n_full++;
			exp.count = fill[CNT_OUT_W-1:0];
			pending_outcomes.push_back(exp);
		endfunction

		function void check_outcome(logic found, logic [CNT_OUT_W-1:0] count,
				logic [STAT_W-1:0] status);
			outcome_t exp;
			if (pending_outcomes.size() == 0) begin
				$error("Result transaction arrived with none outstanding.");
				errors++;
				return;
			end
			exp = pending_outcomes.pop_front();
			if (found !== exp.found) begin
				$error("found: expected %0d, actual %0d", exp.found, found);
				errors++;
			end
			if (count !== exp.count) begin
				$error("count: expected %0d, actual %0d", exp.count, count);
				errors++;
			end
			if (status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_req;
	int hold_left;
	int stall;
	insert_list_tracker sb;

	pil_in_if items_ch ();
	pil_out_if results_ch ();

	positional_insert_list_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_item(logic [MODE_W-1:0] mode, logic signed [VAL_W-1:0] v,
			logic [POS_W-1:0] position);
		while ($urandom_range(99) < tx_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.mode <= mode;
		items_ch.value <= v;
		items_ch.position <= position;
		do
			@(posedge clk);
		while (!items_ch.ready);
	endtask

	task automatic wait_drained();
		items_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_outcomes.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (results_ch.valid && results_ch.ready)
				sb.check_outcome(results_ch.found, results_ch.count, results_ch.status);
			if (items_ch.valid && items_ch.ready)
				sb.accept_item(items_ch.mode, items_ch.value, items_ch.position);
		end
	end

	initial begin
		results_ch.ready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (items_ch.valid && items_ch.ready) ||
					(results_ch.valid && results_ch.ready))
				stall = 0;
			else
				stall++;
		end
		$display("Timed out after %0d cycles without a transaction.", STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int n;
		int r;
		logic [MODE_W-1:0] m;
		logic signed [VAL_W-1:0] v;
		logic [POS_W-1:0] p;

		sb = new();
		hold_req = 1'b0;
		tx_idle_pct = 34;
		rx_idle_pct = 82;
		arst_n = 1'b0;
		items_ch.valid <= 1'b0;
		items_ch.mode <= MODE_INSERT;
		items_ch.value <= '0;
		items_ch.position <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty store, extremes of value and position, every mode.
		send_item(MODE_SEARCH, 32'sh0000_0000, 7'd0);
		send_item(MODE_INSERT, 32'sh1234_5678, 7'd1);
		send_item(MODE_INSERT, 32'sh1234_5678, 7'd127);
		send_item(MODE_APPEND, 32'sh8000_0000, 7'd0);
		send_item(MODE_APPEND, 32'sh7FFF_FFFF, 7'd127);
		send_item(MODE_INSERT, 32'shFFFF_FFFF, 7'd0);
		send_item(MODE_INSERT, 32'sh0000_0000, 7'd3);
		send_item(MODE_INSERT, 32'sh5555_5555, 7'd2);
		send_item(MODE_INSERT, 32'sh5555_5555, 7'd6);
		send_item(MODE_NOP, 32'sh8000_0000, 7'd0);
		send_item(MODE_SEARCH, 32'sh8000_0000, 7'd0);
		send_item(MODE_SEARCH, 32'sh7FFF_FFFF, 7'd0);
		send_item(MODE_SEARCH, 32'shFFFF_FFFF, 7'd127);
		send_item(MODE_SEARCH, 32'sh0000_0000, 7'd0);
		send_item(MODE_SEARCH, 32'sh7FFF_FFFE, 7'd0);
		send_item(MODE_SEARCH, 32'sh5555_5555, 7'd0);
		send_item(MODE_INSERT, 32'shAAAA_AAAA, 7'd5);
		send_item(MODE_APPEND, 32'sh0000_0001, 7'd0);
		send_item(MODE_NOP, 32'shFFFF_FFFF, 7'd127);
		send_item(MODE_SEARCH, 32'sh0000_0001, 7'd0);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 410) begin
				tx_idle_pct = 82;
				rx_idle_pct = 34;
			end
			if (n == 820) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (n == 950)
				hold_req = 1'b1;
			if (n == 1100)
				wait_drained();

			// The store only grows, so growth is kept slow to spread searches over many fill levels.
			r = $urandom_range(99);
			if (n >= 900)
				r = $urandom_range(4) * 20;
			v = $urandom;
			if (sb.fill > 0 && $urandom_range(2) == 0)
				v = sb.cells[$urandom_range(sb.fill - 1)];
			p = $urandom;
			if (r < 5) begin
				m = MODE_INSERT;
				p = $urandom_range(sb.fill);
			end else if (r < 8) begin
				m = MODE_APPEND;
			end else if (r < 12 || r == 20) begin
				m = MODE_INSERT;
				p = $urandom_range(127, sb.fill + 1);
			end else if (r < 15 || r == 40) begin
				m = MODE_NOP;
			end else if (r == 60) begin
				m = MODE_APPEND;
			end else begin
				m = MODE_SEARCH;
			end
			if (n >= 900 && r == 0)
				p = $urandom_range(sb.fill);
			send_item(m, v, p);
		end
		items_ch.valid <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Ran %0d transactions: %0d values stored, %0d searches with %0d hits, %0d no-ops.",
			20 + RANDOM_ITEMS, sb.n_added, sb.n_search, sb.n_hit, sb.n_nop);
		$display("Rejected %0d out-of-range and %0d full inserts; %0d mismatches seen.",
			sb.n_range, sb.n_full, sb.errors);
		if (sb.errors == 0 && sb.pending_outcomes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// File: filelist.f
hw/rtl/pil_pkg.sv
hw/rtl/pil_if.sv
hw/rtl/pil_cell.sv
hw/rtl/positional_insert_list_top.sv
tb/sv/positional_insert_list_top_tb.sv
